// ===== sv/fpsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsr_pkg
// Shared types and constants of the front-panel shift register emulator.
// ----------------------------------------------------------------------------
package fpsr_pkg;

	localparam int unsigned NUM_ENTRIES = 16;
	localparam int unsigned IDX_W       = $clog2(NUM_ENTRIES);

	localparam logic [1:0] OP_BUS_BYTE    = 2'd0;
	localparam logic [1:0] OP_ENCODER     = 2'd1;
	localparam logic [1:0] OP_SWITCH      = 2'd2;
	localparam logic [1:0] OP_LOCAL_READ  = 2'd3;

	localparam logic [7:0] READ_ADDRESS   = 8'h12;
	localparam int unsigned STORE_BIT     = 4;
	localparam logic [IDX_W-1:0] CONTROL_ENTRY = IDX_W'(2);
	localparam logic [7:0] ENTRY_RESET    = 8'hFF;

	localparam logic REG_DETENT_ENABLE = 1'b0;
	localparam logic REG_DETENT_CODE   = 1'b1;

	typedef struct packed {
		logic [1:0] operation;
		logic       data_phase;
		logic [7:0] bus_byte;
		logic [1:0] encoder_bits;
		logic [4:0] switch_levels;
		logic [3:0] read_index;
	} req_t;

	typedef struct packed {
		logic       reply_load;
		logic [7:0] reply_byte;
		logic       driver_enable;
		logic [7:0] read_value;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

endpackage

// ===== sv/fpsr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsr_req_if / fpsr_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface fpsr_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic       data_phase;
	logic [7:0] bus_byte;
	logic [1:0] encoder_bits;
	logic [4:0] switch_levels;
	logic [3:0] read_index;

	modport source (
		output valid, operation, data_phase, bus_byte, encoder_bits,
			switch_levels, read_index,
		input  ready
	);
	modport sink (
		input  valid, operation, data_phase, bus_byte, encoder_bits,
			switch_levels, read_index,
		output ready
	);
endinterface

interface fpsr_rsp_if;
	logic       valid;
	logic       ready;
	logic       reply_load;
	logic [7:0] reply_byte;
	logic       driver_enable;
	logic [7:0] read_value;

	modport source (
		output valid, reply_load, reply_byte, driver_enable, read_value,
		input  ready
	);
	modport sink (
		input  valid, reply_load, reply_byte, driver_enable, read_value,
		output ready
	);
endinterface

// ===== sv/fpsr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsr_ctrl
// Request sequencing: capture, execute, and result valid tracking.
// ----------------------------------------------------------------------------
module fpsr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output fpsr_pkg::cmd_t cmd
);
	import fpsr_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic slot_free;

	assign in_ready    = (state_q == ST_IDLE);
	assign slot_free   = !out_valid_q || out_ready;
	assign cmd.capture = in_valid && in_ready;
	assign cmd.commit  = (state_q == ST_EXEC) && slot_free;
	assign out_valid   = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (cmd.capture) state_d = ST_EXEC;
			ST_EXEC: if (cmd.commit) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== sv/fpsr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsr_datapath
// Panel register file, bus address/driver state, encoder history, result reg.
// ----------------------------------------------------------------------------
module fpsr_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  fpsr_pkg::cmd_t cmd,
	input  fpsr_pkg::req_t req_in,
	input  logic           detent_enable,
	input  logic [1:0]     detent_code,
	output fpsr_pkg::rsp_t rsp_out
);
	import fpsr_pkg::*;

	req_t             req_q;
	logic [7:0]       regs_q [NUM_ENTRIES];
	logic [7:0]       addr_q;
	logic [1:0]       prev_enc_q;
	logic             driving_q;
	rsp_t             rsp_q;

	logic [7:0]       inv_byte;
	logic [7:0]       ctl;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [7:0]       wr_data;
	logic [7:0]       addr_d;
	logic [1:0]       prev_enc_d;
	logic             driving_d;
	rsp_t             rsp_d;
	logic             enc_act;

	assign inv_byte = ~req_q.bus_byte;
	assign ctl      = regs_q[CONTROL_ENTRY];
	assign enc_act  = !(detent_enable && (req_q.encoder_bits != detent_code));

	always_comb begin
		wr_en      = 1'b0;
		wr_idx     = CONTROL_ENTRY;
		wr_data    = ctl;
		addr_d     = addr_q;
		prev_enc_d = prev_enc_q;
		driving_d  = driving_q;
		rsp_d      = '0;
		unique case (req_q.operation)
			OP_BUS_BYTE: begin
				if (!req_q.data_phase) begin
					addr_d = inv_byte;
					if (inv_byte == READ_ADDRESS) begin
						rsp_d.reply_load = 1'b1;
						rsp_d.reply_byte = ctl;
						driving_d        = 1'b1;
						wr_en            = 1'b1;
						wr_data          = {ctl[7:2], 1'b1, ctl[0]};
					end
				end else if (addr_q == READ_ADDRESS) begin
					driving_d = 1'b0;
				end else if (addr_q[STORE_BIT]) begin
					wr_en   = 1'b1;
					wr_idx  = addr_q[IDX_W-1:0];
					wr_data = inv_byte;
				end
			end
			OP_ENCODER: begin
				prev_enc_d = req_q.encoder_bits;
				if (enc_act) begin
					wr_en   = 1'b1;
					wr_data = {ctl[7:2], 1'b0,
						~(prev_enc_q[1] ^ req_q.encoder_bits[0])};
				end
			end
			OP_SWITCH: begin
				wr_en   = 1'b1;
				wr_data = {ctl[7], req_q.switch_levels, ctl[1:0]};
			end
			OP_LOCAL_READ: begin
				rsp_d.read_value = regs_q[req_q.read_index];
			end
			default: ;
		endcase
		rsp_d.driver_enable = driving_d;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			req_q <= req_in;
		if (cmd.commit)
			rsp_q <= rsp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ENTRIES; i++)
				regs_q[i] <= ENTRY_RESET;
			addr_q     <= '0;
			prev_enc_q <= '0;
			driving_q  <= 1'b0;
		end else if (cmd.commit) begin
			if (wr_en)
				regs_q[wr_idx] <= wr_data;
			addr_q     <= addr_d;
			prev_enc_q <= prev_enc_d;
			driving_q  <= driving_d;
		end
	end

	assign rsp_out = rsp_q;

endmodule

// ===== sv/front_panel_shift_register_emulator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// front_panel_shift_register_emulator_core
// Front-panel shift register emulator behind a serial slave: bus bytes,
// encoder events, switch samples and local reads update a 16-entry panel
// register file and produce one result per request.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | operation, data_phase, bus_byte,
//          |     |               | encoder_bits, switch_levels, read_index
//  rsp     | out | valid/ready   | reply_load, reply_byte, driver_enable,
//          |     |               | read_value
//  apb     | in  | psel/penable  | detent_enable (0x0), detent_code (0x4)
//
// A request is captured into the single request register and executed once
// the output register is free; no new request is taken while one executes.
// The result sits in an output register; execution waits only while it is
// still held by a stalled sink.
// Reset clears the sequencer and sets every panel entry to 0xFF.
// ----------------------------------------------------------------------------
module front_panel_shift_register_emulator_core (
	input  logic        clk,
	input  logic        arst_n,
	fpsr_req_if.sink    req,
	fpsr_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import fpsr_pkg::*;

	cmd_t       cmd;
	req_t       req_in;
	rsp_t       rsp_out;
	logic       detent_enable_q;
	logic [1:0] detent_code_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detent_enable_q <= 1'b1;
			detent_code_q   <= 2'd0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_DETENT_ENABLE: detent_enable_q <= pwdata[0];
				REG_DETENT_CODE:   detent_code_q   <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DETENT_ENABLE: prdata = {31'd0, detent_enable_q};
			REG_DETENT_CODE:   prdata = {30'd0, detent_code_q};
			default:           prdata = '0;
		endcase
	end

	assign req_in.operation     = req.operation;
	assign req_in.data_phase    = req.data_phase;
	assign req_in.bus_byte      = req.bus_byte;
	assign req_in.encoder_bits  = req.encoder_bits;
	assign req_in.switch_levels = req.switch_levels;
	assign req_in.read_index    = req.read_index;

	fpsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	fpsr_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.req_in        (req_in),
		.detent_enable (detent_enable_q),
		.detent_code   (detent_code_q),
		.rsp_out       (rsp_out)
	);

	assign rsp.reply_load    = rsp_out.reply_load;
	assign rsp.reply_byte    = rsp_out.reply_byte;
	assign rsp.driver_enable = rsp_out.driver_enable;
	assign rsp.read_value    = rsp_out.read_value;

`ifndef SYNTHESIS
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp.valid)
		else $error("executed request produced no result");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.capture && cmd.commit))
		else $error("capture while a request is executing");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !cmd.commit)
		else $error("held result overwritten");

	a_load_drives: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.reply_load |-> rsp.driver_enable)
		else $error("reply loaded without driver enabled");
`endif

endmodule
